// ===== sv/audio_dac_fifo_with_rate_step_defines.svh =====
// Assertion macros shared by the checker of the audio DAC block.
// No dependencies; take in by `include where assertions are written.
`ifndef AUDIO_DAC_FIFO_WITH_RATE_STEP_DEFINES_SVH
`define AUDIO_DAC_FIFO_WITH_RATE_STEP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ADFRS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ADFRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/adfrs_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the
// audio DAC block. No dependencies.
package adfrs_pkg;

  localparam int FIFO_DEPTH         = 2048;
  localparam int FRAC_BITS          = 12;
  localparam int NEARLY_EMPTY_LEVEL = 128;

  localparam int ADDR_W  = $clog2(FIFO_DEPTH);
  localparam int POS_W   = ADDR_W + FRAC_BITS;
  localparam int PEND_W  = POS_W + 1;
  localparam int STEP_W  = 20;
  localparam int RATE_W  = 17;
  localparam int DIV_W   = STEP_W + FRAC_BITS;
  localparam int DCNT_W  = $clog2(DIV_W);

  localparam logic [RATE_W-1:0] RATE_RESET  = RATE_W'(22050);
  localparam logic [DIV_W-1:0]  BASE_CLK_HZ = DIV_W'(1000000);
  localparam logic [STEP_W-1:0] STEP_MAX    = {STEP_W{1'b1}};
  localparam logic [7:0]        SILENCE     = 8'h80;
  localparam logic [7:0]        UNMAPPED    = 8'hFF;

  localparam logic [PEND_W-1:0] PEND_ONE     = PEND_W'(2 ** FRAC_BITS);
  localparam logic [PEND_W-1:0] PEND_FULL_TH = PEND_W'((FIFO_DEPTH - 1) * (2 ** FRAC_BITS));
  localparam logic [PEND_W-1:0] PEND_NE_TH   = PEND_W'(NEARLY_EMPTY_LEVEL * (2 ** FRAC_BITS));

  // register offsets from the base port
  localparam logic [2:0] OFF_DATA   = 3'd0;
  localparam logic [2:0] OFF_CMD    = 3'd2;
  localparam logic [2:0] OFF_DIV    = 3'd3;
  localparam logic [2:0] OFF_RESET  = 3'd4;
  localparam logic [2:0] OFF_ZERO_A = 3'd5;
  localparam logic [2:0] OFF_ZERO_B = 3'd6;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_DIV1,
    ST_DIV2,
    ST_CLEAR,
    ST_DONE
  } ctl_state_e;

  typedef struct packed {
    logic load;        // capture input item
    logic exec;        // commit the immediate effects of the item
    logic div_start;   // launch divider
    logic div_second;  // second division operands
    logic div_commit;  // write step and run the irq check
    logic fill;        // write silence at fill counter
    logic emit;        // move result into output register
  } ctl_cmd_t;

  typedef struct packed {
    logic is_div;
    logic is_clear;
    logic div_done;
    logic fill_last;
    logic out_free;
  } ctl_sts_t;

endpackage

// ===== sv/adfrs_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on adfrs_pkg.
module adfrs_div
  import adfrs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  num_i,
  input  logic [RATE_W-1:0] den_i,
  output logic              done_o,
  output logic [DIV_W-1:0]  quot_o
);

  logic [DIV_W-1:0]  num_q, num_d;
  logic [RATE_W-1:0] rem_q, rem_d;
  logic [RATE_W-1:0] den_q;
  logic [DCNT_W-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [RATE_W:0]   shifted, diff;
  logic              ge;

  always_comb begin
    shifted = {rem_q, num_q[DIV_W-1]};
    diff    = shifted - {1'b0, den_q};
    ge      = shifted >= {1'b0, den_q};
    rem_d   = ge ? diff[RATE_W-1:0] : shifted[RATE_W-1:0];
    num_d   = {num_q[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == DCNT_W'(DIV_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DCNT_W'(DIV_W - 1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// ===== sv/adfrs_datapath.sv =====
// Datapath: register file, sample FIFO memory, pending/position arithmetic,
// output register. Depends on adfrs_pkg and adfrs_div.
module adfrs_datapath
  import adfrs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctl_cmd_t          cmd_i,
  output ctl_sts_t          sts_o,
  input  logic [1:0]        opcode_i,
  input  logic [2:0]        port_offset_i,
  input  logic [7:0]        write_data_i,
  input  logic              cfg_we_i,
  input  logic [RATE_W-1:0] cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        read_data_o,
  output logic [7:0]        sample_out_o,
  output logic              irq_line_o
);

  // item and result registers
  op_e        op_q;
  logic [2:0] off_q;
  logic [7:0] wd_q;
  logic [7:0] res_rd_q, res_smp_q;
  logic [7:0] out_rd_q, out_smp_q;
  logic       out_irq_q;

  // control state
  logic [ADDR_W-1:0] wp_q;
  logic [POS_W-1:0]  pos_q;
  logic [STEP_W-1:0] step_q;
  logic [PEND_W-1:0] pend_q;
  logic [7:0]        cmd_byte_q, div_byte_q;
  logic              irq_st_q, armed_q, level_q;
  logic [RATE_W-1:0] rate_q;
  logic [ADDR_W-1:0] fill_cnt_q;
  logic              out_valid_q;

  logic [7:0] mem [FIFO_DEPTH];
  logic [7:0] rdata_q;

  logic              full, empty, nempty, irq_fire;
  logic [7:0]        status;
  logic              is_data_wr, data_we;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;
  logic [STEP_W-1:0] step_sat;
  logic [PEND_W-1:0] step_ext;

  logic              div_done;
  logic [DIV_W-1:0]  div_num, quot;
  logic [RATE_W-1:0] div_den;

  always_comb begin
    empty    = (pend_q == '0);
    full     = (pend_q > PEND_FULL_TH);
    nempty   = (pend_q < PEND_NE_TH) && (cmd_byte_q[1:0] == 2'b11);
    irq_fire = nempty && armed_q;
    status   = {4'b0000, full, empty, nempty, irq_st_q};
    step_ext = PEND_W'(step_q);
    is_data_wr = (op_q == OP_WRITE) && (off_q == OFF_DATA);
    data_we  = cmd_i.exec && is_data_wr && !full;
    mem_we   = cmd_i.fill || data_we;
    mem_addr = cmd_i.fill ? fill_cnt_q : wp_q;
    mem_wdata = cmd_i.fill ? SILENCE : wd_q;
    step_sat = (|quot[DIV_W-1:STEP_W]) ? STEP_MAX : quot[STEP_W-1:0];
    div_num  = cmd_i.div_second ? {quot[STEP_W-1:0], {FRAC_BITS{1'b0}}} : BASE_CLK_HZ;
    div_den  = cmd_i.div_second ? rate_q : ({{(RATE_W-8){1'b0}}, wd_q} + RATE_W'(1));
  end

  adfrs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // sample store; read port follows the playback position every cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata_q <= mem[pos_q[POS_W-1 -: ADDR_W]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      pos_q       <= '0;
      step_q      <= '0;
      pend_q      <= '0;
      cmd_byte_q  <= '0;
      div_byte_q  <= '0;
      irq_st_q    <= 1'b0;
      armed_q     <= 1'b0;
      level_q     <= 1'b0;
      rate_q      <= RATE_RESET;
      fill_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) rate_q <= cfg_data_i;
      if (cmd_i.fill) fill_cnt_q <= fill_cnt_q + 1'b1;

      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;

      if (cmd_i.exec) begin
        unique case (op_q)
          OP_WRITE: begin
            unique case (off_q)
              OFF_DATA: begin
                if (!full) begin
                  wp_q   <= wp_q + 1'b1;
                  pend_q <= pend_q + PEND_ONE;
                end
              end
              OFF_CMD: begin
                cmd_byte_q <= wd_q;
                if (wd_q[1:0] != 2'b00) armed_q <= 1'b1;
              end
              OFF_RESET: begin
                if (wd_q == 8'h00) begin
                  level_q <= 1'b0;
                  armed_q <= 1'b0;
                  wp_q    <= '0;
                  pos_q   <= '0;
                  step_q  <= '0;
                  pend_q  <= '0;
                end
              end
              default: ;
            endcase
          end
          OP_TICK: begin
            if (irq_fire) begin
              irq_st_q <= 1'b1;
              armed_q  <= 1'b0;
              level_q  <= 1'b1;
            end
            if (!empty) begin
              pos_q  <= pos_q + POS_W'(step_q);
              pend_q <= (pend_q > step_ext) ? (pend_q - step_ext) : '0;
            end
          end
          default: ;
        endcase
      end

      if (cmd_i.div_commit) begin
        div_byte_q <= wd_q;
        step_q     <= step_sat;
        if (irq_fire) begin
          irq_st_q <= 1'b1;
          armed_q  <= 1'b0;
          level_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(opcode_i);
      off_q <= port_offset_i;
      wd_q  <= write_data_i;
    end
    if (cmd_i.exec) begin
      unique case (op_q)
        OP_READ: begin
          res_smp_q <= SILENCE;
          // offset 2 on a read is the status register
          unique case (off_q) inside
            OFF_DATA:               res_rd_q <= cmd_byte_q;
            OFF_CMD:                res_rd_q <= status;
            OFF_DIV:                res_rd_q <= div_byte_q;
            OFF_ZERO_A, OFF_ZERO_B: res_rd_q <= 8'h00;
            default:                res_rd_q <= UNMAPPED;
          endcase
        end
        OP_TICK: begin
          res_rd_q  <= 8'h00;
          res_smp_q <= empty ? SILENCE : rdata_q;
        end
        default: begin
          res_rd_q  <= 8'h00;
          res_smp_q <= SILENCE;
        end
      endcase
    end
    if (cmd_i.emit) begin
      out_rd_q  <= res_rd_q;
      out_smp_q <= res_smp_q;
      out_irq_q <= level_q;
    end
  end

  always_comb begin
    sts_o.is_div    = (op_q == OP_WRITE) && (off_q == OFF_DIV);
    sts_o.is_clear  = (op_q == OP_WRITE) && (off_q == OFF_RESET) && (wd_q == 8'h00);
    sts_o.div_done  = div_done;
    sts_o.fill_last = (fill_cnt_q == {ADDR_W{1'b1}});
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = out_rd_q;
  assign sample_out_o = out_smp_q;
  assign irq_line_o   = out_irq_q;

endmodule

// ===== sv/adfrs_ctrl.sv =====
// Controller: after the power-up silence fill, sequences one item at a time
// through execute, divide, clear and result hand-off. Depends on adfrs_pkg.
module adfrs_ctrl
  import adfrs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ctl_sts_t sts_i,
  output ctl_cmd_t cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_INIT;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.fill = 1'b1;
        if (sts_i.fill_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.is_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV1;
        end else if (sts_i.is_clear) begin
          state_d = ST_CLEAR;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIV1: begin
        if (sts_i.div_done) begin
          cmd_o.div_start  = 1'b1;
          cmd_o.div_second = 1'b1;
          state_d          = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (sts_i.div_done) begin
          cmd_o.div_commit = 1'b1;
          state_d          = ST_DONE;
        end
      end
      ST_CLEAR: begin
        cmd_o.fill = 1'b1;
        if (sts_i.fill_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/audio_dac_fifo_with_rate_step.sv =====
// Byte-register audio DAC with a 2048-byte sample FIFO and fixed-point
// playback step; one result per accepted item. Bus reads, data/command
// writes and sample ticks pass capture, execute and hand-off to the output
// register before the next accept. A divisor write runs two 32-step
// restoring divisions one after the other on the one shared divider. A
// reset write (offset 4, data zero) and the power-up reset both sweep
// silence through every sample memory entry, one entry a cycle, with input
// stalled; rate writes are taken throughout. The output register lets the
// next item be accepted while a result waits.
// Depends on adfrs_pkg, adfrs_ctrl, adfrs_datapath, adfrs_div.
module audio_dac_fifo_with_rate_step
  import adfrs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        opcode_i,
  input  logic [2:0]        port_offset_i,
  input  logic [7:0]        write_data_i,
  input  logic              cfg_we_i,
  input  logic [RATE_W-1:0] cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        read_data_o,
  output logic [7:0]        sample_out_o,
  output logic              irq_line_o
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  adfrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  adfrs_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_i      (opcode_i),
    .port_offset_i (port_offset_i),
    .write_data_i  (write_data_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_data_o   (read_data_o),
    .sample_out_o  (sample_out_o),
    .irq_line_o    (irq_line_o)
  );

endmodule

// ===== sv/adfrs_checker.sv =====
// Port-level checker for the audio DAC block, bound to the top level.
// Depends on the assertion macros header.
`include "audio_dac_fifo_with_rate_step_defines.svh"

module adfrs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [7:0]        read_data_o,
  input logic [7:0]        sample_out_o,
  input logic              irq_line_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  // one item in flight: input closes right after a transfer
  `ADFRS_ASSERT_NEXT(a_single_item, clk_i, rst_ni, in_xfer, in_stall_o, "accept not followed by stall")
  // a new result is only handed off while the input side is closed
  `ADFRS_ASSERT_NOW(a_emit_busy, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "result emitted while idle")
  `ADFRS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "output valid dropped under stall")
  `ADFRS_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(read_data_o) && $stable(sample_out_o) && $stable(irq_line_o), "output payload changed under stall")

endmodule

bind audio_dac_fifo_with_rate_step adfrs_checker u_checker (.*);
